/* design/msrg_pkg.sv */
`default_nettype none

package msrg_pkg;

    localparam int W_STEP      = 24;
    localparam int W_DUR       = 15;
    localparam int W_PULSE     = 8;
    localparam int W_LEAD      = 2;
    localparam int MAX_AXES    = 4;
    localparam int W_ACC       = W_STEP + 1;
    localparam int W_REM       = W_STEP + 2;
    localparam int W_DIV       = W_STEP + 3;
    localparam int W_CNT       = $clog2(W_DIV);

    localparam int AXIS_COUNT_DEFAULT = 4;

    localparam logic [W_PULSE-1:0] PULSE_HIGH_RESET = 8'd2;
    localparam logic [W_DUR-1:0]   DUR_MAX          = 15'h7fff;
    localparam logic [W_STEP-1:0]  PERIOD_MAX       = 24'hff_ffff;

    // s_axis_tdata layout
    localparam int OFS_TOTAL  = 0;
    localparam int OFS_ACCEL  = OFS_TOTAL + W_STEP;
    localparam int OFS_CRUISE = OFS_ACCEL + W_STEP;
    localparam int OFS_LEAD   = OFS_CRUISE + W_STEP;
    localparam int OFS_FIRST  = OFS_LEAD + W_LEAD;
    localparam int OFS_AXIS   = OFS_FIRST + W_STEP;
    localparam int IN_BITS    = OFS_AXIS + MAX_AXES * W_STEP;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // m_axis_tdata layout
    localparam int OFS_MASK    = 0;
    localparam int OFS_LOW     = OFS_MASK + MAX_AXES;
    localparam int OFS_IDLE1   = OFS_LOW + W_DUR;
    localparam int OFS_IDLE2   = OFS_IDLE1 + W_DUR;
    localparam int OFS_PERIOD  = OFS_IDLE2 + W_DUR;
    localparam int OUT_BITS    = OFS_PERIOD + W_STEP;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_RUN,
        ST_APPLY,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_FIRST,
        MODE_ACCEL,
        MODE_CRUISE,
        MODE_DECEL
    } mode_t;

endpackage

`default_nettype wire

/* design/multi_axis_step_ramp_generator.sv */
// Stepper ramp generator for up to four axes with one master axis.
// s_axis: tuser selects the command (0 loads a motion block from tdata,
// 1 advances one master step). A load gives no beat.
// A step beat yields one m_axis beat with the step mask, pulse-low ticks,
// the two idle halves, the period and tlast on the final step of the block.
// A step after the block has ended is dropped in ST_CHECK.
// A step passes through ST_CHECK, ST_SETUP, ST_RUN, ST_APPLY and ST_EMIT.
// While the ramp accelerates or decelerates, ST_RUN also runs the 27-bit
// bit-serial divider; on the first and the cruise steps it walks the axes
// only. One step is in work at a time; s_axis_tready is high only while the
// core is idle, and a finished step waits in ST_EMIT while the output
// register is full and m_axis_tready is low.
// The output register holds a finished beat while m_axis_tready is low, and
// the core takes and works the next beat meanwhile; it then waits with its
// result until the output register frees.
// cfg carries pulse_high_ticks; write it only while the block is idle.
// Reset: no block loaded (steps are dropped), pulse_high_ticks = 2,
// output register empty.
`default_nettype none

module multi_axis_step_ramp_generator
    import msrg_pkg::*;
#(
    parameter int AXIS_COUNT = AXIS_COUNT_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // total_steps, accel_count, cruise_count, lead_axis, first_delay,
    // axis0_steps .. axis3_steps
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // step_mask, pulse_low, idle_first, idle_second, period_ticks
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    // last_step
    output logic                        m_axis_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [W_PULSE-1:0]     cfg_data
);

    localparam int AXW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam logic [W_CNT-1:0] LAST_DIV  = W_CNT'(W_DIV - 1);
    localparam logic [W_CNT-1:0] LAST_AXIS = W_CNT'(2 * AXIS_COUNT - 1);

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    logic [W_PULSE-1:0] pht_reg;
    logic [W_STEP-1:0]  total_reg;
    logic [W_STEP-1:0]  accel_reg;
    logic [W_ACC-1:0]   decel_start_reg;
    logic [W_LEAD-1:0]  master_reg;
    logic [W_STEP-1:0]  period_reg;
    logic [W_REM-1:0]   rem_reg;
    logic [W_STEP-1:0]  step_index_reg;
    logic [W_ACC-1:0]   acc_reg [AXIS_COUNT];
    logic [W_STEP-1:0]  count_reg [AXIS_COUNT];
    logic [AXIS_COUNT-1:0] mask_reg;
    logic [W_CNT-1:0]   cnt_reg;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;

    logic accept, out_free, arith, run_done;
    logic div_load, div_iter;
    logic [W_DIV-1:0] dividend, divisor, quotient, div_rem;
    logic [W_STEP-1:0] n_eff;

    logic [AXW-1:0]    ax;
    logic              is_master;
    logic [W_ACC-1:0]  acc_sum;

    logic [W_STEP+1:0] grown;
    logic [W_STEP-1:0] period_next;
    logic [W_STEP-1:0] low_raw, half1_raw, half2_raw;
    logic [W_DUR-1:0]  low_sat, half1_sat, half2_sat;
    logic [W_STEP-1:0] step_inc;

    assign accept    = s_axis_tvalid & s_axis_tready;
    assign out_free  = ~out_valid_reg | m_axis_tready;
    assign arith     = (mode_reg == MODE_ACCEL) || (mode_reg == MODE_DECEL);
    assign run_done  = cnt_reg == (arith ? LAST_DIV : LAST_AXIS);
    assign cfg_ready = 1'b1;

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        div_load      = 1'b0;
        div_iter      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (accept && s_axis_tuser == CMD_STEP)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (step_index_reg >= total_reg)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                div_load   = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                div_iter = 1'b1;
                if (run_done)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ramp phase of this step
    always_comb
    begin
        priority if (step_index_reg == '0)
            mode_next = MODE_FIRST;
        else if (step_index_reg < accel_reg)
            mode_next = MODE_ACCEL;
        else if ({1'b0, step_index_reg} >= decel_start_reg)
            mode_next = MODE_DECEL;
        else
            mode_next = MODE_CRUISE;
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pht_reg <= PULSE_HIGH_RESET;
        else if (cfg_valid && cfg_ready)
            pht_reg <= cfg_data;
    end

    // ---------------- block state ----------------
    assign step_inc = step_index_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= '0;
            step_index_reg <= '0;
        end
        else if (accept && s_axis_tuser == CMD_LOAD)
        begin
            total_reg      <= s_axis_tdata[OFS_TOTAL +: W_STEP];
            step_index_reg <= '0;
        end
        else if (state_reg == ST_EMIT && out_free)
            step_index_reg <= step_inc;
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == CMD_LOAD)
        begin
            accel_reg       <= s_axis_tdata[OFS_ACCEL +: W_STEP];
            decel_start_reg <= {1'b0, s_axis_tdata[OFS_ACCEL +: W_STEP]}
                             + {1'b0, s_axis_tdata[OFS_CRUISE +: W_STEP]};
            master_reg      <= s_axis_tdata[OFS_LEAD +: W_LEAD];
        end
        if (state_reg == ST_CHECK)
            mode_reg <= mode_next;
    end

    // ---------------- divider ----------------
    assign n_eff    = (mode_reg == MODE_DECEL) ? total_reg - step_index_reg
                                               : step_index_reg;
    assign divisor  = {1'b0, n_eff, 2'b01};
    assign dividend = {2'b00, period_reg, 1'b0} + {1'b0, rem_reg};

    msrg_div u_div (
        .clk       (clk),
        .load      (div_load),
        .iter      (div_iter),
        .dividend  (dividend),
        .divisor   (divisor),
        .quotient  (quotient),
        .remainder (div_rem)
    );

    // ---------------- period update ----------------
    assign grown = {2'b00, period_reg} + {1'b0, quotient[W_STEP:0]};

    always_comb
    begin
        period_next = period_reg;
        unique case (mode_reg)
            MODE_ACCEL:
                period_next = period_reg - quotient[W_STEP-1:0];
            MODE_DECEL:
                period_next = (grown[W_STEP+1:W_STEP] != 2'b00) ? PERIOD_MAX
                                                                : grown[W_STEP-1:0];
            MODE_FIRST, MODE_CRUISE:
                period_next = period_reg;
            default:
                period_next = period_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == CMD_LOAD)
        begin
            period_reg <= s_axis_tdata[OFS_FIRST +: W_STEP];
            rem_reg    <= '0;
        end
        else if (state_reg == ST_APPLY)
        begin
            period_reg <= period_next;
            if (mode_reg == MODE_FIRST)
                rem_reg <= '0;
            else if (arith)
                rem_reg <= div_rem[W_REM-1:0];
        end
    end

    // ---------------- Bresenham axes ----------------
    // Per axis: first add the axis count, then compare and fold back.
    assign ax        = cnt_reg[AXW:1];
    assign is_master = W_LEAD'(ax) == master_reg;
    assign acc_sum   = acc_reg[ax] + {1'b0, count_reg[ax]};

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == CMD_LOAD)
        begin
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                acc_reg[a]   <= '0;
                count_reg[a] <= s_axis_tdata[OFS_AXIS + a * W_STEP +: W_STEP];
            end
        end
        else if (state_reg == ST_RUN && cnt_reg <= LAST_AXIS && !is_master)
        begin
            if (!cnt_reg[0])
                acc_reg[ax] <= acc_sum;
            else if (acc_reg[ax] >= {1'b0, total_reg})
                acc_reg[ax] <= acc_reg[ax] - {1'b0, total_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            cnt_reg  <= '0;
            mask_reg <= '0;
        end
        else if (state_reg == ST_RUN)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg <= LAST_AXIS)
            begin
                if (is_master)
                    mask_reg[ax] <= 1'b1;
                else if (cnt_reg[0] && acc_reg[ax] >= {1'b0, total_reg})
                    mask_reg[ax] <= 1'b1;
            end
        end
    end

    // ---------------- pulse timing ----------------
    always_comb
    begin
        low_raw   = (period_reg > {{(W_STEP-W_PULSE){1'b0}}, pht_reg})
                  ? period_reg - {{(W_STEP-W_PULSE){1'b0}}, pht_reg}
                  : W_STEP'(1);
        half1_raw = (period_reg > W_STEP'(1)) ? {1'b0, period_reg[W_STEP-1:1]}
                                              : W_STEP'(1);
        half2_raw = (period_reg > W_STEP'(1))
                  ? period_reg - {1'b0, period_reg[W_STEP-1:1]}
                  : W_STEP'(1);
        low_sat   = (low_raw[W_STEP-1:W_DUR] != '0) ? DUR_MAX : low_raw[W_DUR-1:0];
        half1_sat = (half1_raw[W_STEP-1:W_DUR] != '0) ? DUR_MAX : half1_raw[W_DUR-1:0];
        half2_sat = (half2_raw[W_STEP-1:W_DUR] != '0) ? DUR_MAX : half2_raw[W_DUR-1:0];
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_EMIT && out_free)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            out_data_reg[OUT_TDATA_W-1:OUT_BITS]  <= '0;
            out_data_reg[OFS_MASK +: MAX_AXES]    <= MAX_AXES'(mask_reg);
            out_data_reg[OFS_LOW +: W_DUR]        <= low_sat;
            out_data_reg[OFS_IDLE1 +: W_DUR]      <= half1_sat;
            out_data_reg[OFS_IDLE2 +: W_DUR]      <= half2_sat;
            out_data_reg[OFS_PERIOD +: W_STEP]    <= period_reg;
            out_last_reg                          <= step_inc == total_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("output beat appeared without a finished step");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_index_reg <= total_reg)
        else $error("step index ran past the block total");

    a_accel_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY && mode_reg == MODE_ACCEL)
            |=> period_reg <= $past(period_reg))
        else $error("period grew while accelerating");

endmodule

`default_nettype wire

/* design/msrg_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle while iter is high.
module msrg_div
    import msrg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             load,
    input  wire logic             iter,
    input  wire logic [W_DIV-1:0] dividend,
    input  wire logic [W_DIV-1:0] divisor,
    output logic      [W_DIV-1:0] quotient,
    output logic      [W_DIV-1:0] remainder
);

    logic [W_DIV-1:0] quo_reg;
    logic [W_DIV-1:0] rem_reg;
    logic [W_DIV-1:0] dsr_reg;
    logic [W_DIV-1:0] quo_next;
    logic [W_DIV-1:0] rem_next;
    logic [W_DIV:0]   shifted;
    logic [W_DIV+1:0] trial;
    logic             fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[W_DIV-1]};
        trial    = {1'b0, shifted} - {2'b00, dsr_reg};
        fits     = ~trial[W_DIV+1];
        rem_next = fits ? trial[W_DIV-1:0] : shifted[W_DIV-1:0];
        quo_next = {quo_reg[W_DIV-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (iter)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
